FILE: rtl/core/bslpd_pkg.sv
package bslpd_pkg;

  localparam int unsigned KEY_SLOTS    = 4;
  localparam int unsigned KEY_NUM_W    = 3;
  localparam int unsigned LIMIT_W      = 16;
  localparam int unsigned MIN_PRESS_MS = 30;
  localparam int unsigned CFG_INDEX_W  = 2;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned IN_TDATA_W   = 8;
  localparam int unsigned OUT_TDATA_W  = 8;

  localparam logic [KEY_SLOTS-1:0]  IDLE_MASK_RST   = '0;
  localparam logic [CFG_DATA_W-1:0] SHORT_LIMIT_RST = 64'h01F4_01F4_01F4_01F4;
  localparam logic [CFG_DATA_W-1:0] LONG_LIMIT_RST  = 64'h03E8_03E8_03E8_03E8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IDLE_MASK   = 2'd0,
    REG_SHORT_LIMIT = 2'd1,
    REG_LONG_LIMIT  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [KEY_SLOTS-1:0]  idle_mask;
    logic [CFG_DATA_W-1:0] short_lim;
    logic [CFG_DATA_W-1:0] long_lim;
  } cfg_t;

  // per-key events of one tick; kind bit set means long press
  typedef struct packed {
    logic [KEY_SLOTS-1:0] hit;
    logic [KEY_SLOTS-1:0] kind;
  } evt_rec_t;

endpackage

FILE: rtl/core/bslpd_front.sv
module bslpd_front
  import bslpd_pkg::*;
#(
  parameter int unsigned NUM_KEYS   = 4,
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KEY_SLOTS-1:0] levels,
  input  cfg_t                 cfg,
  input  logic                 q_full,
  output logic                 push,
  output evt_rec_t             rec
);

  localparam int unsigned CMP_W = (TIME_WIDTH > LIMIT_W) ? TIME_WIDTH : LIMIT_W;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

  logic accept;
  logic [KEY_SLOTS-1:0] hit;
  logic [KEY_SLOTS-1:0] kind;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  genvar i;
  generate
    for (i = 0; i < KEY_SLOTS; i++) begin : g_key
      if (i < NUM_KEYS) begin : g_used
        logic                  prev;
        logic                  armed;
        logic [TIME_WIDTH-1:0] cnt;
        logic                  prev_next;
        logic                  armed_next;
        logic [TIME_WIDTH-1:0] cnt_next;
        logic [TIME_WIDTH-1:0] cnt_inc;
        logic [CMP_W-1:0]      inc_x;
        logic [CMP_W-1:0]      cnt_x;
        logic                  changed;
        logic                  is_short;
        logic                  is_long;
        logic                  arm_mid;

        always_comb begin
          cnt_inc   = (cnt == TIME_MAX) ? cnt : cnt + 1'b1;
          inc_x     = CMP_W'(cnt_inc);
          changed   = levels[i] != prev;
          is_short  = 1'b0;
          prev_next = levels[i];
          if (changed && (levels[i] != cfg.idle_mask[i])) begin
            cnt_next = '0;
            arm_mid  = 1'b1;
          end else if (changed) begin
            is_short = (inc_x > CMP_W'(MIN_PRESS_MS)) &&
                       (inc_x < CMP_W'(cfg.short_lim[LIMIT_W*i +: LIMIT_W]));
            cnt_next = '0;
            arm_mid  = 1'b0;
          end else begin
            cnt_next = cnt_inc;
            arm_mid  = armed;
          end
          cnt_x      = CMP_W'(cnt_next);
          is_long    = arm_mid && (cnt_x > CMP_W'(cfg.long_lim[LIMIT_W*i +: LIMIT_W]));
          armed_next = arm_mid && !is_long;
        end

        always_ff @(posedge clk) begin
          if (rst) begin
            prev  <= 1'b0;
            armed <= 1'b0;
            cnt   <= '0;
          end else if (accept) begin
            prev  <= prev_next;
            armed <= armed_next;
            cnt   <= cnt_next;
          end
        end

        assign hit[i]  = is_short || is_long;
        assign kind[i] = is_long;
      end else begin : g_unused
        assign hit[i]  = 1'b0;
        assign kind[i] = 1'b0;
      end
    end
  endgenerate

  // ticks without events never reach the queue
  assign push     = accept && (|hit);
  assign rec.hit  = hit;
  assign rec.kind = kind;

endmodule

FILE: rtl/core/bslpd_queue.sv
module bslpd_queue
  import bslpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  evt_rec_t wr_rec,
  input  logic     pop,
  output evt_rec_t rd_rec,
  output logic     full,
  output logic     empty
);

  evt_rec_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full   = count == 2'd2;
  assign empty  = count == 2'd0;
  assign rd_rec = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/core/bslpd_back.sv
module bslpd_back
  import bslpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  evt_rec_t             rec,
  input  logic                 q_empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KEY_NUM_W-1:0] out_key,
  output logic                 out_kind,
  output logic                 out_last
);

  logic [KEY_SLOTS-1:0] pend;
  logic [KEY_SLOTS-1:0] kind;
  logic [KEY_SLOTS-1:0] low_bit;
  logic [KEY_SLOTS-1:0] rest;
  logic [KEY_NUM_W-1:0] key_num;
  logic                 out_load;
  logic                 adv;

  always_comb begin
    low_bit = pend & (~pend + 1'b1);
    rest    = pend & ~low_bit;
    key_num = '0;
    for (int k = 0; k < KEY_SLOTS; k++) begin
      if (low_bit[k]) begin
        key_num = KEY_NUM_W'(k + 1);
      end
    end
    out_load = !out_valid || out_ready;
    adv      = (|pend) && out_load;
    // refill as the last key of the current tick goes out
    pop      = !q_empty && (!(|pend) || (adv && (rest == '0)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        pend <= rec.hit;
      end else if (adv) begin
        pend <= rest;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind <= rec.kind;
    end
    if (adv) begin
      out_key  <= key_num;
      out_kind <= |(kind & low_bit);
      out_last <= rest == '0;
    end
  end

endmodule

FILE: rtl/core/button_short_long_press_detector.sv
// An event reaches m_axis through the queue, the pending register and the output register.
// Throughput: one tick beat per cycle while the queue is not full; a tick with n events
// sends n event beats, one per cycle while m_axis_tready is high, set by the single output register.
// A two-entry queue between the key tracker and the event serializer absorbs bursts.
// Reset (rst, synchronous): all keys released and disarmed, counters zero,
// registers back to idle mask 0, short limits 500 ms, long limits 1000 ms.
module button_short_long_press_detector
  import bslpd_pkg::*;
#(
  parameter int unsigned NUM_KEYS   = 4,
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [3:0] key_levels
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [2:0] key_number
  output logic                   m_axis_tuser,  // [0] press_kind
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t                 cfg;
  evt_rec_t             wr_rec;
  evt_rec_t             rd_rec;
  logic                 push;
  logic                 pop;
  logic                 q_full;
  logic                 q_empty;
  logic [KEY_NUM_W-1:0] out_key;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_mask <= IDLE_MASK_RST;
      cfg.short_lim <= SHORT_LIMIT_RST;
      cfg.long_lim  <= LONG_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_IDLE_MASK:   cfg.idle_mask <= cfg_data[KEY_SLOTS-1:0];
        REG_SHORT_LIMIT: cfg.short_lim <= cfg_data;
        REG_LONG_LIMIT:  cfg.long_lim  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bslpd_front #(
    .NUM_KEYS  (NUM_KEYS),
    .TIME_WIDTH(TIME_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .levels  (s_axis_tdata[KEY_SLOTS-1:0]),
    .cfg     (cfg),
    .q_full  (q_full),
    .push    (push),
    .rec     (wr_rec)
  );

  bslpd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wr_rec(wr_rec),
    .pop   (pop),
    .rd_rec(rd_rec),
    .full  (q_full),
    .empty (q_empty)
  );

  bslpd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rec      (rd_rec),
    .q_empty  (q_empty),
    .pop      (pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_key  (out_key),
    .out_kind (m_axis_tuser),
    .out_last (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-KEY_NUM_W){1'b0}}, out_key};

endmodule

FILE: rtl/core/bslpd_checker.sv
module bslpd_checker
  import bslpd_pkg::*;
#(
  parameter int unsigned NUM_KEYS = 4
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser,
  input logic                   m_axis_tlast
);

  // stalled event beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("event beat changed while stalled");

  a_key_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata != '0) &&
      (m_axis_tdata <= OUT_TDATA_W'(NUM_KEYS)))
    else $error("key number out of range");

  // nothing can come out before the first tick beat has gone in
  a_no_spurious: assert property (@(posedge clk)
    $past(rst) && !(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
    else $error("event without a tick");

  a_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("event valid right after reset");

endmodule

bind button_short_long_press_detector bslpd_checker #(
  .NUM_KEYS(NUM_KEYS)
) u_bslpd_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
